[rtl/core/v3au_pkg.sv]
package v3au_pkg;

  // default component format, signed Q16.16
  localparam int DEF_COMPONENT_WIDTH = 32;
  localparam int DEF_FRACTION_BITS   = 16;

  typedef enum logic [3:0] {
    CMD_ADD    = 4'd0,
    CMD_SUB    = 4'd1,
    CMD_SCALE  = 4'd2,
    CMD_DIVIDE = 4'd3,
    CMD_NEGATE = 4'd4,
    CMD_DOT    = 4'd5,
    CMD_LENSQ  = 4'd6,
    CMD_LEN    = 4'd7,
    CMD_CROSS  = 4'd8,
    CMD_UNIT   = 4'd9,
    CMD_PROJ   = 4'd10,
    CMD_REJ    = 4'd11,
    CMD_EQUAL  = 4'd12
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DIV_ZERO  = 2'd1,
    ST_SATURATED = 2'd2
  } status_t;

endpackage

[rtl/core/v3au_lane.sv]
module v3au_lane #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  input  logic signed [W-1:0]   s,
  input  logic signed [W-1:0]   a_n1,
  input  logic signed [W-1:0]   b_n1,
  input  logic signed [W-1:0]   a_n2,
  input  logic signed [W-1:0]   b_n2,
  output logic signed [2*W-1:0] ab,
  output logic signed [2*W-1:0] aa,
  output logic signed [2*W-1:0] bb,
  output logic signed [2*W-1:0] sa,
  output logic signed [2*W-1:0] c1,
  output logic signed [2*W-1:0] c2
);

  // one component's share of every product the commands need
  always_ff @(posedge clk) begin
    if (en) begin
      ab <= a * b;
      aa <= a * a;
      bb <= b * b;
      sa <= a * s;
      c1 <= a_n1 * b_n2;
      c2 <= a_n2 * b_n1;
    end
  end

endmodule

[rtl/core/v3au_sqrt.sv]
module v3au_sqrt #(
  parameter int RW = 32,
  parameter int TW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            v_in,
  input  logic [2*RW-1:0] n,
  input  logic [TW-1:0]   tag_in,
  output logic            v_out,
  output logic [RW-1:0]   root,
  output logic [TW-1:0]   tag_out
);

  localparam int IW = 2 * RW;

  logic [IW-1:0] rem_q [RW+1];
  logic [IW-1:0] res_q [RW+1];
  logic [TW-1:0] tag_q [RW+1];
  logic [RW:0]   v_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[RW-1:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= n;
      res_q[0] <= '0;
      tag_q[0] <= tag_in;
    end
  end

  // one result bit per stage, trial bit walks down by powers of four
  for (genvar k = 0; k < RW; k++) begin : g_step
    localparam int BP = 2 * (RW - 1 - k);
    logic [IW-1:0] trial;
    logic          take;

    assign trial = res_q[k] + (IW'(1) << BP);
    assign take  = rem_q[k] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= take ? rem_q[k] - trial : rem_q[k];
        res_q[k+1] <= take ? (res_q[k] >> 1) + (IW'(1) << BP) : res_q[k] >> 1;
        tag_q[k+1] <= tag_q[k];
      end
    end
  end

  assign v_out   = v_q[RW];
  assign root    = res_q[RW][RW-1:0];
  assign tag_out = tag_q[RW];

endmodule

[rtl/core/v3au_div.sv]
module v3au_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QB = 51,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          v_in,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          v_out,
  output logic [QB-1:0] quo,
  output logic          ovf,
  output logic [TW-1:0] tag_out
);

  localparam int CW = NW + DW + QB;

  logic [NW-1:0] rem_q [QB+1];
  logic [DW-1:0] den_q [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic [TW-1:0] tag_q [QB+1];
  logic [QB:0]   v_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[QB-1:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= num;
      den_q[0] <= den;
      quo_q[0] <= '0;
      tag_q[0] <= tag_in;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int J = QB - 1 - k;
    logic [CW-1:0] trial;
    logic          take;
    logic [QB-1:0] quo_next;

    assign trial = CW'(den_q[k]) << J;
    assign take  = CW'(rem_q[k]) >= trial;

    always_comb begin
      quo_next    = quo_q[k];
      quo_next[J] = take;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= take ? NW'(CW'(rem_q[k]) - trial) : rem_q[k];
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= quo_next;
        tag_q[k+1] <= tag_q[k];
      end
    end
  end

  // a remainder still at or above the divisor means the quotient needs more bits
  assign ovf     = CW'(rem_q[QB]) >= CW'(den_q[QB]);
  assign v_out   = v_q[QB];
  assign quo     = quo_q[QB];
  assign tag_out = tag_q[QB];

endmodule

[rtl/core/vector3_arithmetic_unit.sv]
// three-component vector alu on signed fixed-point values (Q16.16 by default)
// input channel: in_valid/in_ready, one request carries command, vectors a and b and
//   scalar_in; output channel: out_valid/out_ready, one result per request, in order
// results: res_x/res_y/res_z vector, res_scalar, is_equal, status (ok, divide by zero,
//   saturated); fields a command does not produce read zero
// long path, sized from COMPONENT_WIDTH and FRACTION_BITS (Q16.16 by default): the
//   bit-per-stage square root (COMPONENT_WIDTH + 1 stages) followed by the bit-per-stage
//   dividers (COMPONENT_WIDTH + FRACTION_BITS + 4 stages)
// throughput: one request per cycle while no result waits on out_ready; every request
//   walks the full pipeline so results leave in the order taken
// three component lanes form all products in parallel, a merge stage sums them, then
//   the shared root and the divider lanes finish length, unit, divide and projection
// reset: synchronous, clears every stage valid and out_valid; nothing else is needed
// stall: while a result waits on out_ready the whole pipeline holds and in_ready is low;
//   in_ready is high whenever the output register is empty or being emptied
module vector3_arithmetic_unit import v3au_pkg::*; #(
  parameter int COMPONENT_WIDTH = DEF_COMPONENT_WIDTH,
  parameter int FRACTION_BITS   = DEF_FRACTION_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [3:0]                        command,
  input  logic signed [COMPONENT_WIDTH-1:0] a_x,
  input  logic signed [COMPONENT_WIDTH-1:0] a_y,
  input  logic signed [COMPONENT_WIDTH-1:0] a_z,
  input  logic signed [COMPONENT_WIDTH-1:0] b_x,
  input  logic signed [COMPONENT_WIDTH-1:0] b_y,
  input  logic signed [COMPONENT_WIDTH-1:0] b_z,
  input  logic signed [COMPONENT_WIDTH-1:0] scalar_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [COMPONENT_WIDTH-1:0] res_x,
  output logic signed [COMPONENT_WIDTH-1:0] res_y,
  output logic signed [COMPONENT_WIDTH-1:0] res_z,
  output logic signed [COMPONENT_WIDTH-1:0] res_scalar,
  output logic                              is_equal,
  output logic [1:0]                        status
);

  localparam int W   = COMPONENT_WIDTH;
  localparam int F   = FRACTION_BITS;
  localparam int PW  = 2 * W;          // one product
  localparam int DTW = 2 * W + 2;      // sum of three products
  localparam int QB  = W + F + 3;      // quotient bits kept by the dividers
  localparam int QL  = QB / 2;         // low slice of the projection ratio
  localparam int QH  = QB - QL;        // high slice
  localparam int PRW = QB + W + 1;     // projection product
  localparam int XW  = 2 * W + F + 6;  // common width ahead of saturation
  localparam int NWL = W + F;          // lane dividend
  localparam int NWP = 2 * W + F;      // projection dividend

  localparam logic signed [XW-1:0] SAT_MAX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] SAT_MIN = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

  typedef struct packed {
    cmd_t             cmd;
    logic [2:0][W-1:0] a;
    logic [2:0][W-1:0] b;
    logic [W-1:0]     s;
    logic [DTW-1:0]   dab;
    logic [DTW-1:0]   dbb;
    logic [2:0][W-1:0] e_vec;
    logic [W-1:0]     e_sc;
    logic             e_eq;
    logic             e_clamp;
  } main_tag_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [2:0][W-1:0] a;
    logic [2:0][W-1:0] b;
    logic [2:0][W-1:0] e_vec;
    logic [W-1:0]     e_sc;
    logic             e_eq;
    logic             e_clamp;
    logic [W-1:0]     len;
    logic             dz;
    logic             psign;
  } proj_tag_t;

  // clamp to the component range, top bit flags a clamp
  function automatic logic [W:0] sat_f(input logic signed [XW-1:0] x);
    logic [W:0] r;
    if (x > SAT_MAX) begin
      r = {1'b1, SAT_MAX[W-1:0]};
    end else if (x < SAT_MIN) begin
      r = {1'b1, SAT_MIN[W-1:0]};
    end else begin
      r = {1'b0, x[W-1:0]};
    end
    return r;
  endfunction

  logic en;

  // global advance: the pipeline moves whenever the output register can take a result
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // input register
  logic                s1_v;
  cmd_t                s1_cmd;
  logic signed [W-1:0] s1_a [3];
  logic signed [W-1:0] s1_b [3];
  logic signed [W-1:0] s1_s;

  // product stage, lanes hold the products
  logic                 s2_v;
  cmd_t                 s2_cmd;
  logic signed [W-1:0]  s2_a [3];
  logic signed [W-1:0]  s2_b [3];
  logic signed [W-1:0]  s2_s;
  logic signed [PW-1:0] p_ab [3];
  logic signed [PW-1:0] p_aa [3];
  logic signed [PW-1:0] p_bb [3];
  logic signed [PW-1:0] p_sa [3];
  logic signed [PW-1:0] p_c1 [3];
  logic signed [PW-1:0] p_c2 [3];

  // merge stage
  logic                  s3_v;
  cmd_t                  s3_cmd;
  logic signed [W-1:0]   s3_a [3];
  logic signed [W-1:0]   s3_b [3];
  logic signed [W-1:0]   s3_s;
  logic signed [DTW-1:0] s3_dab;
  logic signed [DTW-1:0] s3_daa;
  logic signed [DTW-1:0] s3_dbb;
  logic signed [PW-1:0]  s3_sa [3];
  logic signed [PW:0]    s3_cr [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd  <= cmd_t'(command);
      s1_a[0] <= a_x;
      s1_a[1] <= a_y;
      s1_a[2] <= a_z;
      s1_b[0] <= b_x;
      s1_b[1] <= b_y;
      s1_b[2] <= b_z;
      s1_s    <= scalar_in;
      s2_cmd  <= s1_cmd;
      s2_a    <= s1_a;
      s2_b    <= s1_b;
      s2_s    <= s1_s;
      s3_cmd  <= s2_cmd;
      s3_a    <= s2_a;
      s3_b    <= s2_b;
      s3_s    <= s2_s;
      s3_dab  <= DTW'(p_ab[0]) + DTW'(p_ab[1]) + DTW'(p_ab[2]);
      s3_daa  <= DTW'(p_aa[0]) + DTW'(p_aa[1]) + DTW'(p_aa[2]);
      s3_dbb  <= DTW'(p_bb[0]) + DTW'(p_bb[1]) + DTW'(p_bb[2]);
      s3_sa   <= p_sa;
      for (int i = 0; i < 3; i++) begin
        s3_cr[i] <= (PW+1)'(p_c1[i]) - (PW+1)'(p_c2[i]);
      end
    end
  end

  // lane i also forms the two cross terms of component i
  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3au_lane #(.W(W)) u_lane (
      .clk  (clk),
      .en   (en),
      .a    (s1_a[i]),
      .b    (s1_b[i]),
      .s    (s1_s),
      .a_n1 (s1_a[(i+1)%3]),
      .b_n1 (s1_b[(i+1)%3]),
      .a_n2 (s1_a[(i+2)%3]),
      .b_n2 (s1_b[(i+2)%3]),
      .ab   (p_ab[i]),
      .aa   (p_aa[i]),
      .bb   (p_bb[i]),
      .sa   (p_sa[i]),
      .c1   (p_c1[i]),
      .c2   (p_c2[i])
    );
  end

  // results that are final after the merge: add, sub, scale, negate, dot, lensq,
  // cross and equal; all others leave these at zero
  logic signed [XW-1:0] ev_raw [3];
  logic [W:0]           ev_sat [3];
  logic signed [XW-1:0] es_raw;
  logic [W:0]           es_sat;
  main_tag_t            mt_in;

  always_comb begin
    es_raw = '0;
    for (int i = 0; i < 3; i++) begin
      ev_raw[i] = '0;
    end
    unique case (s3_cmd)
      CMD_ADD: begin
        for (int i = 0; i < 3; i++) ev_raw[i] = XW'(s3_a[i]) + XW'(s3_b[i]);
      end
      CMD_SUB: begin
        for (int i = 0; i < 3; i++) ev_raw[i] = XW'(s3_a[i]) - XW'(s3_b[i]);
      end
      CMD_NEGATE: begin
        for (int i = 0; i < 3; i++) ev_raw[i] = -XW'(s3_a[i]);
      end
      CMD_SCALE: begin
        for (int i = 0; i < 3; i++) ev_raw[i] = XW'(s3_sa[i] >>> F);
      end
      CMD_CROSS: begin
        for (int i = 0; i < 3; i++) ev_raw[i] = XW'(s3_cr[i] >>> F);
      end
      CMD_DOT:   es_raw = XW'(s3_dab >>> F);
      CMD_LENSQ: es_raw = XW'(s3_daa >>> F);
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      ev_sat[i] = sat_f(ev_raw[i]);
    end
    es_sat = sat_f(es_raw);

    mt_in.cmd = s3_cmd;
    for (int i = 0; i < 3; i++) begin
      mt_in.a[i]     = s3_a[i];
      mt_in.b[i]     = s3_b[i];
      mt_in.e_vec[i] = ev_sat[i][W-1:0];
    end
    mt_in.s       = s3_s;
    mt_in.dab     = s3_dab;
    mt_in.dbb     = s3_dbb;
    mt_in.e_sc    = es_sat[W-1:0];
    mt_in.e_eq    = (s3_cmd == CMD_EQUAL) && (s3_a[0] == s3_b[0]) &&
                    (s3_a[1] == s3_b[1]) && (s3_a[2] == s3_b[2]);
    mt_in.e_clamp = ev_sat[0][W] | ev_sat[1][W] | ev_sat[2][W] | es_sat[W];
  end

  // length of a, shared by len and unit
  logic                      sq_v;
  logic [W-1:0]              sq_len;
  logic [$bits(main_tag_t)-1:0] sq_tag;

  v3au_sqrt #(.RW(W), .TW($bits(main_tag_t))) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .v_in    (s3_v),
    .n       (s3_daa[PW-1:0]),
    .tag_in  (mt_in),
    .v_out   (sq_v),
    .root    (sq_len),
    .tag_out (sq_tag)
  );

  // divider operands: magnitudes in, sign applied after
  main_tag_t        mt_out;
  proj_tag_t        pt_in;
  logic             divide_cmd;
  logic [W-1:0]     s_abs;
  logic [W-1:0]     lane_den;
  logic [W-1:0]     a_abs [3];
  logic [NWL-1:0]   lane_num [3];
  logic             lane_sign [3];
  logic [DTW-1:0]   dab_abs;
  logic [NWP-1:0]   proj_num;

  always_comb begin
    mt_out     = main_tag_t'(sq_tag);
    divide_cmd = mt_out.cmd == CMD_DIVIDE;
    s_abs      = mt_out.s[W-1] ? ~mt_out.s + 1'b1 : mt_out.s;
    lane_den   = divide_cmd ? s_abs : sq_len;
    for (int i = 0; i < 3; i++) begin
      a_abs[i]     = mt_out.a[i][W-1] ? ~mt_out.a[i] + 1'b1 : mt_out.a[i];
      lane_num[i]  = {a_abs[i], {F{1'b0}}};
      lane_sign[i] = mt_out.a[i][W-1] ^ (divide_cmd & mt_out.s[W-1]);
    end
    dab_abs  = mt_out.dab[DTW-1] ? ~mt_out.dab + 1'b1 : mt_out.dab;
    proj_num = {dab_abs[PW-1:0], {F{1'b0}}};

    pt_in.cmd     = mt_out.cmd;
    pt_in.a       = mt_out.a;
    pt_in.b       = mt_out.b;
    pt_in.e_vec   = mt_out.e_vec;
    pt_in.e_sc    = mt_out.e_sc;
    pt_in.e_eq    = mt_out.e_eq;
    pt_in.e_clamp = mt_out.e_clamp;
    pt_in.len     = sq_len;
    pt_in.psign   = mt_out.dab[DTW-1];
    pt_in.dz      = (divide_cmd && mt_out.s == '0) ||
                    (mt_out.cmd == CMD_UNIT && sq_len == '0) ||
                    ((mt_out.cmd == CMD_PROJ || mt_out.cmd == CMD_REJ) && mt_out.dbb == '0);
  end

  logic [QB-1:0] ld_quo [3];
  logic          ld_sign [3];

  for (genvar i = 0; i < 3; i++) begin : g_ldiv
    v3au_div #(.NW(NWL), .DW(W), .QB(QB), .TW(1)) u_div (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .v_in    (sq_v),
      .num     (lane_num[i]),
      .den     (lane_den),
      .tag_in  (lane_sign[i]),
      .v_out   (),
      .quo     (ld_quo[i]),
      .ovf     (),
      .tag_out (ld_sign[i])
    );
  end

  // projection ratio a.b / b.b, clamped where it would saturate anyway
  logic                         pd_v;
  logic [QB-1:0]                pd_quo;
  logic                         pd_ovf;
  logic [$bits(proj_tag_t)-1:0] pd_tag;

  v3au_div #(.NW(NWP), .DW(PW), .QB(QB), .TW($bits(proj_tag_t))) u_pdiv (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .v_in    (sq_v),
    .num     (proj_num),
    .den     (mt_out.dbb[PW-1:0]),
    .tag_in  (pt_in),
    .v_out   (pd_v),
    .quo     (pd_quo),
    .ovf     (pd_ovf),
    .tag_out (pd_tag)
  );

  // stage 5: signed lane quotients, ratio times b in two slices
  proj_tag_t pt_out;
  logic [QB-1:0] rq;

  assign pt_out = proj_tag_t'(pd_tag);
  assign rq     = pd_ovf ? {QB{1'b1}} : pd_quo;

  logic                    s5_v;
  proj_tag_t               s5_t;
  logic signed [QB:0]      s5_vq [3];
  logic signed [QL+W:0]    s5_mlo [3];
  logic signed [QH+W:0]    s5_mhi [3];

  // stage 6: full projection product with the ratio sign
  logic                    s6_v;
  proj_tag_t               s6_t;
  logic signed [QB:0]      s6_vq [3];
  logic signed [PRW-1:0]   s6_sp [3];
  logic signed [PRW-1:0]   pr_sum [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr_sum[i] = (PRW'(s5_mhi[i]) <<< QL) + PRW'(s5_mlo[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else if (en) begin
      s5_v <= pd_v;
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_t  <= pt_out;
      s6_t  <= s5_t;
      s6_vq <= s5_vq;
      for (int i = 0; i < 3; i++) begin
        s5_vq[i]  <= ld_sign[i] ? -$signed({1'b0, ld_quo[i]}) : $signed({1'b0, ld_quo[i]});
        s5_mlo[i] <= $signed({1'b0, rq[QL-1:0]}) * $signed(pt_out.b[i]);
        s5_mhi[i] <= $signed({1'b0, rq[QB-1:QL]}) * $signed(pt_out.b[i]);
        s6_sp[i]  <= s5_t.psign ? -pr_sum[i] : pr_sum[i];
      end
    end
  end

  // final selection and saturation for divide, unit, proj, rej and len
  logic signed [PRW-1:0] p_fl [3];
  logic signed [XW-1:0]  lv_raw [3];
  logic [W:0]            lv_sat [3];
  logic [W:0]            len_sat;
  logic [W-1:0]          fv [3];
  logic [W-1:0]          fsc;
  logic                  fclamp;
  status_t               fstatus;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_fl[i]   = s6_sp[i] >>> F;
      lv_raw[i] = '0;
      unique case (s6_t.cmd)
        CMD_DIVIDE, CMD_UNIT: lv_raw[i] = XW'(s6_vq[i]);
        CMD_PROJ:             lv_raw[i] = XW'(p_fl[i]);
        CMD_REJ:              lv_raw[i] = XW'($signed(s6_t.a[i])) - XW'(p_fl[i]);
        default: ;
      endcase
      lv_sat[i] = sat_f(lv_raw[i]);
      fv[i]     = s6_t.dz ? '0 : (lv_sat[i][W-1:0] | s6_t.e_vec[i]);
    end
    len_sat = sat_f((s6_t.cmd == CMD_LEN) ? XW'($signed({1'b0, s6_t.len})) : '0);
    fsc     = len_sat[W-1:0] | s6_t.e_sc;
    fclamp  = s6_t.e_clamp | len_sat[W] | lv_sat[0][W] | lv_sat[1][W] | lv_sat[2][W];
    priority if (s6_t.dz) begin
      fstatus = ST_DIV_ZERO;
    end else if (fclamp) begin
      fstatus = ST_SATURATED;
    end else begin
      fstatus = ST_OK;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s6_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_x      <= fv[0];
      res_y      <= fv[1];
      res_z      <= fv[2];
      res_scalar <= fsc;
      is_equal   <= s6_t.e_eq;
      status     <= fstatus;
    end
  end

`ifndef SYNTHESIS
  a_rst_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set right after reset");
  a_divzero_zeros: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DIV_ZERO |->
      res_x == '0 && res_y == '0 && res_z == '0 && res_scalar == '0 && !is_equal)
    else $error("divide by zero result carries data");
  a_equal_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_equal |->
      status == ST_OK && res_x == '0 && res_y == '0 && res_z == '0 && res_scalar == '0)
    else $error("equality result carries data or a bad status");
`endif

endmodule
